>>> design/ddtc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddtc_pkg
// Shared types and constants for the dual deadline timer compare block.
// ----------------------------------------------------------------------------
package ddtc_pkg;

    localparam int NUM_CORES   = 4;
    localparam int CORE_W      = 2;
    localparam int CORE_IDX_W  = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam int TIME_W      = 64;
    localparam int PERIOD_W    = 32;
    localparam int DELTA_W     = 32;
    localparam int KIND_W      = 3;
    localparam int OP_W        = 3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [TIME_W-1:0]   NEVER_DEADLINE = {TIME_W{1'b1}};
    localparam logic [PERIOD_W-1:0] PERIOD_RESET   = PERIOD_W'(1000);

    // Input kind codes
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_START   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ARM     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DISARM  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SERVICE = 3'd4;

    // Internal operation codes carried through the queue
    localparam logic [OP_W-1:0] OP_NONE    = 3'd0;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd1;
    localparam logic [OP_W-1:0] OP_TICK    = 3'd2;
    localparam logic [OP_W-1:0] OP_ARM     = 3'd3;
    localparam logic [OP_W-1:0] OP_DISARM  = 3'd4;
    localparam logic [OP_W-1:0] OP_SERVICE = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              core_ok;
        logic [CORE_W-1:0] core;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] sum;     // now + period or now + delta
    } item_t;

endpackage
`default_nettype wire

>>> design/dual_deadline_timer_compare.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dual_deadline_timer_compare
// Per-core timer compare value from a periodic tick and a one-shot deadline.
//
// Input channel (in_valid / in_stall) carries kind, core, now and delta; one
// result transfer (out_valid / out_stall) follows every input transfer, in
// order, with core_out, compare_value and the two expiry flags.
// The period register is written through cfg_wr_en / cfg_wr_data; the user
// must write it only while the block is idle, which the block itself does
// not enforce. It resets to 1000. The front decodes and forms now + period
// or now + delta into a two-entry queue; the back end takes the head item,
// updates the core's deadlines and registers the minimum in the result
// register. Throughput is one item per cycle while out_stall is low,
// limited by the single read-modify-write of the deadline registers.
// Reset sets every deadline to all ones, empties the queue and drops
// out_valid. While out_stall is high the result holds and the queue keeps
// taking items until both entries are used, then in_stall rises.
// ----------------------------------------------------------------------------
module dual_deadline_timer_compare
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [ddtc_pkg::PERIOD_W-1:0]     cfg_wr_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [ddtc_pkg::KIND_W-1:0]       kind,
    input  wire logic [ddtc_pkg::CORE_W-1:0]       core,
    input  wire logic [ddtc_pkg::TIME_W-1:0]       now,
    input  wire logic [ddtc_pkg::DELTA_W-1:0]      delta,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [ddtc_pkg::CORE_W-1:0]            core_out,
    output logic [ddtc_pkg::TIME_W-1:0]            compare_value,
    output logic                                   oneshot_expired,
    output logic                                   tick_expired
);

    ddtc_pkg::item_t               front_item;
    ddtc_pkg::item_t               head_item;
    logic [ddtc_pkg::PERIOD_W-1:0] period;
    logic                          full;
    logic                          empty;
    logic                          push;
    logic                          pop;

    assign in_stall = full;
    assign push     = in_valid && !full;

    ddtc_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .kind        (kind),
        .core        (core),
        .now         (now),
        .delta       (delta),
        .item        (front_item),
        .period      (period)
    );

    ddtc_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .head_item (head_item),
        .full      (full),
        .empty     (empty)
    );

    ddtc_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_item       (head_item),
        .empty           (empty),
        .period          (period),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .core_out        (core_out),
        .compare_value   (compare_value),
        .oneshot_expired (oneshot_expired),
        .tick_expired    (tick_expired)
    );

endmodule
`default_nettype wire

>>> design/ddtc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddtc_front
// Holds the period register, decodes the kind and forms the new deadline.
// ----------------------------------------------------------------------------
module ddtc_front
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [ddtc_pkg::PERIOD_W-1:0]   cfg_wr_data,
    input  wire logic [ddtc_pkg::KIND_W-1:0]     kind,
    input  wire logic [ddtc_pkg::CORE_W-1:0]     core,
    input  wire logic [ddtc_pkg::TIME_W-1:0]     now,
    input  wire logic [ddtc_pkg::DELTA_W-1:0]    delta,
    output ddtc_pkg::item_t                      item,
    output logic [ddtc_pkg::PERIOD_W-1:0]        period
);

    logic [ddtc_pkg::PERIOD_W-1:0] tick_period_reg;
    logic [ddtc_pkg::TIME_W-1:0]   offset;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_period_reg <= ddtc_pkg::PERIOD_RESET;
        end
        else if (cfg_wr_en)
        begin
            tick_period_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        case (kind)
            ddtc_pkg::KIND_CLEAR:   item.op = ddtc_pkg::OP_CLEAR;
            ddtc_pkg::KIND_START:   item.op = ddtc_pkg::OP_TICK;
            ddtc_pkg::KIND_ARM:     item.op = ddtc_pkg::OP_ARM;
            ddtc_pkg::KIND_DISARM:  item.op = ddtc_pkg::OP_DISARM;
            ddtc_pkg::KIND_SERVICE: item.op = ddtc_pkg::OP_SERVICE;
            default:                item.op = ddtc_pkg::OP_NONE;
        endcase

        // one shared adder: delta for arm, period otherwise
        if (kind == ddtc_pkg::KIND_ARM)
        begin
            offset = ddtc_pkg::TIME_W'(delta);
        end
        else
        begin
            offset = ddtc_pkg::TIME_W'(tick_period_reg);
        end

        item.core_ok = ({1'b0, core} < (ddtc_pkg::CORE_W + 1)'(ddtc_pkg::NUM_CORES));
        item.core    = core;
        item.now     = now;
        item.sum     = now + offset;
    end

    assign period = tick_period_reg;

endmodule
`default_nettype wire

>>> design/ddtc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddtc_queue
// Short FIFO between the decode front and the deadline back end.
// ----------------------------------------------------------------------------
module ddtc_queue
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  ddtc_pkg::item_t      push_item,
    input  wire logic            pop,
    output ddtc_pkg::item_t      head_item,
    output logic                 full,
    output logic                 empty
);

    ddtc_pkg::item_t               entry_reg [ddtc_pkg::QUEUE_DEPTH];
    logic [ddtc_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [ddtc_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [ddtc_pkg::QCNT_W-1:0]   count_reg;
    logic [ddtc_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [ddtc_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [ddtc_pkg::QCNT_W-1:0]   count_next;

    localparam logic [ddtc_pkg::QPTR_W-1:0] PTR_LAST = ddtc_pkg::QPTR_W'(ddtc_pkg::QUEUE_DEPTH - 1);
    localparam logic [ddtc_pkg::QCNT_W-1:0] CNT_FULL = ddtc_pkg::QCNT_W'(ddtc_pkg::QUEUE_DEPTH);

    assign full      = (count_reg == CNT_FULL);
    assign empty     = (count_reg == '0);
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

endmodule
`default_nettype wire

>>> design/ddtc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddtc_back
// Per-core deadline registers, update and compare-value result register.
// ----------------------------------------------------------------------------
module ddtc_back
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  ddtc_pkg::item_t                        head_item,
    input  wire logic                              empty,
    input  wire logic [ddtc_pkg::PERIOD_W-1:0]     period,
    output logic                                   pop,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [ddtc_pkg::CORE_W-1:0]            core_out,
    output logic [ddtc_pkg::TIME_W-1:0]            compare_value,
    output logic                                   oneshot_expired,
    output logic                                   tick_expired
);

    logic [ddtc_pkg::TIME_W-1:0]   tick_deadline_reg    [ddtc_pkg::NUM_CORES];
    logic [ddtc_pkg::TIME_W-1:0]   oneshot_deadline_reg [ddtc_pkg::NUM_CORES];

    logic                          out_valid_reg;
    logic [ddtc_pkg::CORE_W-1:0]   core_out_reg;
    logic [ddtc_pkg::TIME_W-1:0]   compare_value_reg;
    logic                          oneshot_expired_reg;
    logic                          tick_expired_reg;

    logic [ddtc_pkg::CORE_IDX_W-1:0] idx;
    logic [ddtc_pkg::TIME_W-1:0]     tick_cur;
    logic [ddtc_pkg::TIME_W-1:0]     oneshot_cur;
    logic [ddtc_pkg::TIME_W-1:0]     tick_next;
    logic [ddtc_pkg::TIME_W-1:0]     oneshot_next;
    logic [ddtc_pkg::TIME_W-1:0]     compare_next;
    logic                            os_hit;
    logic                            tk_hit;

    // result register frees up when empty or being taken this cycle
    assign pop = !empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        idx          = head_item.core[ddtc_pkg::CORE_IDX_W-1:0];
        tick_cur     = tick_deadline_reg[idx];
        oneshot_cur  = oneshot_deadline_reg[idx];
        tick_next    = tick_cur;
        oneshot_next = oneshot_cur;
        os_hit       = 1'b0;
        tk_hit       = 1'b0;

        case (head_item.op)
            ddtc_pkg::OP_CLEAR:
            begin
                tick_next    = ddtc_pkg::NEVER_DEADLINE;
                oneshot_next = ddtc_pkg::NEVER_DEADLINE;
            end
            ddtc_pkg::OP_TICK:
            begin
                tick_next = head_item.sum;
            end
            ddtc_pkg::OP_ARM:
            begin
                oneshot_next = head_item.sum;
            end
            ddtc_pkg::OP_DISARM:
            begin
                oneshot_next = ddtc_pkg::NEVER_DEADLINE;
            end
            ddtc_pkg::OP_SERVICE:
            begin
                os_hit = (head_item.now >= oneshot_cur);
                tk_hit = (head_item.now >= tick_cur);
                if (os_hit)
                begin
                    oneshot_next = ddtc_pkg::NEVER_DEADLINE;
                end
                if (tk_hit)
                begin
                    // advance from the old deadline, wraps modulo 2^64
                    tick_next = tick_cur + ddtc_pkg::TIME_W'(period);
                end
            end
            default:
            begin
                tick_next    = tick_cur;
                oneshot_next = oneshot_cur;
            end
        endcase

        if (head_item.core_ok)
        begin
            compare_next = (tick_next < oneshot_next) ? tick_next : oneshot_next;
        end
        else
        begin
            compare_next = ddtc_pkg::NEVER_DEADLINE;
            os_hit       = 1'b0;
            tk_hit       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ddtc_pkg::NUM_CORES; i++)
            begin
                tick_deadline_reg[i]    <= ddtc_pkg::NEVER_DEADLINE;
                oneshot_deadline_reg[i] <= ddtc_pkg::NEVER_DEADLINE;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && head_item.core_ok)
            begin
                tick_deadline_reg[idx]    <= tick_next;
                oneshot_deadline_reg[idx] <= oneshot_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            core_out_reg        <= head_item.core;
            compare_value_reg   <= compare_next;
            oneshot_expired_reg <= os_hit;
            tick_expired_reg    <= tk_hit;
        end
    end

    assign out_valid       = out_valid_reg;
    assign core_out        = core_out_reg;
    assign compare_value   = compare_value_reg;
    assign oneshot_expired = oneshot_expired_reg;
    assign tick_expired    = tick_expired_reg;

    a_bad_core_never: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !head_item.core_ok) |=>
            (compare_value_reg == ddtc_pkg::NEVER_DEADLINE)
            && !oneshot_expired_reg && !tick_expired_reg)
        else $error("out-of-range core gave a live result");

    a_clear_never: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head_item.core_ok && (head_item.op == ddtc_pkg::OP_CLEAR)) |=>
            (compare_value_reg == ddtc_pkg::NEVER_DEADLINE))
        else $error("clear did not give a never deadline");

    a_flags_service_only: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (head_item.op != ddtc_pkg::OP_SERVICE)) |=>
            !oneshot_expired_reg && !tick_expired_reg)
        else $error("expiry flag outside service");

endmodule
`default_nettype wire

>>> dv/tb_dual_deadline_timer_compare.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_deadline_timer_compare
// Self-checking bench for the per-core tick / one-shot compare multiplexer.
// A clocked driver feeds operations from a queue and a monitor predicts each
// compare result from shadow deadline state, then checks the result stream
// in order. Random gaps and stalls on both channels, one long output hold
// to back the block up, and period changes between drained phases.
// ----------------------------------------------------------------------------
module tb_dual_deadline_timer_compare;

    import ddtc_pkg::*;

    localparam logic [KIND_W-1:0] KIND_RSVD_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_RSVD_LAST  = 3'd7;
    localparam int unsigned       LONG_HOLD       = 300;
    localparam int unsigned       IDLE_LIMIT      = 5000;

    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [CORE_W-1:0]   core;
        logic [TIME_W-1:0]   now;
        logic [DELTA_W-1:0]  delta;
    } timer_op_t;

    typedef struct {
        logic [CORE_W-1:0]   core;
        logic [TIME_W-1:0]   compare;
        logic                oneshot;
        logic                tick;
    } timer_result_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [PERIOD_W-1:0]   cfg_wr_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [KIND_W-1:0]     kind = '0;
    logic [CORE_W-1:0]     core = '0;
    logic [TIME_W-1:0]     now = '0;
    logic [DELTA_W-1:0]    delta = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [CORE_W-1:0]     core_out;
    logic [TIME_W-1:0]     compare_value;
    logic                  oneshot_expired;
    logic                  tick_expired;

    // shadow of the block's state
    logic [PERIOD_W-1:0]   period_model = PERIOD_RESET;
    logic [TIME_W-1:0]     tick_due [NUM_CORES] = '{default: NEVER_DEADLINE};
    logic [TIME_W-1:0]     shot_due [NUM_CORES] = '{default: NEVER_DEADLINE};

    timer_op_t             timer_ops [$];
    timer_result_t         compare_expected [$];
    timer_result_t         want;
    timer_op_t             sent_op;
    logic                  in_taken = 1'b0;
    logic                  no_idle = 1'b0;
    int unsigned           send_gap = 0;
    int unsigned           stall_left = 0;
    int unsigned           hold_requests = 0;
    int unsigned           holds_done = 0;
    int unsigned           idle_cycles = 0;
    int unsigned           mismatches = 0;
    logic [TIME_W-1:0]     time_base = '0;

    dual_deadline_timer_compare dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .core            (core),
        .now             (now),
        .delta           (delta),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .core_out        (core_out),
        .compare_value   (compare_value),
        .oneshot_expired (oneshot_expired),
        .tick_expired    (tick_expired)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Updates the shadow deadlines for one operation and returns its result.
    function automatic timer_result_t apply_timer_op(input timer_op_t op);
        timer_result_t res;
        int            c;
        res.core    = op.core;
        res.compare = NEVER_DEADLINE;
        res.oneshot = 1'b0;
        res.tick    = 1'b0;
        c = int'(op.core);
        if (c < NUM_CORES)
        begin
            case (op.kind)
                KIND_CLEAR:
                begin
                    tick_due[c] = NEVER_DEADLINE;
                    shot_due[c] = NEVER_DEADLINE;
                end
                KIND_START:   tick_due[c] = op.now + TIME_W'(period_model);
                KIND_ARM:     shot_due[c] = op.now + TIME_W'(op.delta);
                KIND_DISARM:  shot_due[c] = NEVER_DEADLINE;
                KIND_SERVICE:
                begin
                    if (op.now >= shot_due[c])
                    begin
                        shot_due[c] = NEVER_DEADLINE;
                        res.oneshot = 1'b1;
                    end
                    // tick moves on from the old deadline, not from now
                    if (op.now >= tick_due[c])
                    begin
                        tick_due[c] = tick_due[c] + TIME_W'(period_model);
                        res.tick    = 1'b1;
                    end
                end
                default: ;
            endcase
            res.compare = (tick_due[c] < shot_due[c]) ? tick_due[c] : shot_due[c];
        end
        return res;
    endfunction

    function automatic int unsigned draw_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Sender: holds a stalled transfer, otherwise gaps or takes the next op.
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !in_taken)
            ;
        else if (send_gap > 0)
        begin
            send_gap--;
            in_valid <= 1'b0;
        end
        else if (timer_ops.size() > 0)
        begin
            sent_op = timer_ops.pop_front();
            kind     <= sent_op.kind;
            core     <= sent_op.core;
            now      <= sent_op.now;
            delta    <= sent_op.delta;
            in_valid <= 1'b1;
            send_gap = draw_gap();
        end
        else
            in_valid <= 1'b0;
    end

    // Receiver back-pressure, including the requested long hold.
    always @(negedge clk)
    begin
        if (hold_requests != holds_done)
        begin
            holds_done++;
            stall_left = LONG_HOLD;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            stall_left = draw_gap();
            out_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // Monitor: period writes, result checks, then prediction of new input.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
                period_model = cfg_wr_data;
            if (out_valid && !out_stall)
            begin
                if (compare_expected.size() == 0)
                begin
                    $error("result for core %0d with nothing outstanding", core_out);
                    mismatches++;
                end
                else
                begin
                    want = compare_expected.pop_front();
                    if (core_out !== want.core)
                    begin
                        $error("core_out mismatch: expected %0d, got %0d", want.core, core_out);
                        mismatches++;
                    end
                    if (compare_value !== want.compare)
                    begin
                        $error("compare_value mismatch: expected %h, got %h",
                               want.compare, compare_value);
                        mismatches++;
                    end
                    if (oneshot_expired !== want.oneshot)
                    begin
                        $error("oneshot_expired mismatch: expected %b, got %b",
                               want.oneshot, oneshot_expired);
                        mismatches++;
                    end
                    if (tick_expired !== want.tick)
                    begin
                        $error("tick_expired mismatch: expected %b, got %b",
                               want.tick, tick_expired);
                        mismatches++;
                    end
                end
            end
            in_taken = in_valid && !in_stall;
            if (in_taken)
                compare_expected.push_back(apply_timer_op('{kind, core, now, delta}));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_dual_deadline_timer_compare NOT OK");
                $finish;
            end
        end
    end

    task automatic add_op(input logic [KIND_W-1:0] k, input int unsigned c,
                          input logic [TIME_W-1:0] t, input logic [DELTA_W-1:0] d);
        timer_op_t op;
        op.kind  = k;
        op.core  = CORE_W'(c);
        op.now   = t;
        op.delta = d;
        timer_ops.push_back(op);
    endtask

    // Sequences follow a rising time base so services land around deadlines.
    task automatic run_random(input int count);
        int unsigned pick;
        int unsigned span;
        int          i;
        logic [KIND_W-1:0]  k;
        logic [TIME_W-1:0]  t;
        logic [DELTA_W-1:0] d;
        span = (period_model < 3) ? 4 : period_model / 3;
        for (i = 0; i < count; i++)
        begin
            time_base += $urandom_range(0, span);
            if ($urandom_range(0, 99) < 3)
                time_base += TIME_W'($urandom) << $urandom_range(0, 31);
            t = ($urandom_range(0, 99) < 10) ? {$urandom, $urandom} : time_base;
            d = ($urandom_range(0, 99) < 25) ? $urandom : $urandom_range(0, span);
            pick = $urandom_range(0, 99);
            if (pick < 4)
                k = KIND_CLEAR;
            else if (pick < 18)
                k = KIND_START;
            else if (pick < 38)
                k = KIND_ARM;
            else if (pick < 44)
                k = KIND_DISARM;
            else if (pick < 92)
                k = KIND_SERVICE;
            else
                k = KIND_W'($urandom_range(KIND_RSVD_FIRST, KIND_RSVD_LAST));
            add_op(k, $urandom_range(0, NUM_CORES - 1), t, d);
        end
    endtask

    // Waits until every op is sent and every result is checked, then lets the block settle.
    task automatic drain();
        @(posedge clk) #1;
        while (timer_ops.size() != 0 || in_valid || compare_expected.size() != 0)
            @(posedge clk) #1;
        repeat (3) @(posedge clk);
        #1;
    endtask

    task automatic set_period(input logic [PERIOD_W-1:0] p);
        drain();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= p;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk) #1;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk) #1;

        // reset period: never-deadlines, wrap of the all-ones deadline,
        // expiry on the exact deadline, reserved kinds, field extremes
        add_op(KIND_SERVICE, 0, '0, '0);
        add_op(KIND_SERVICE, 1, NEVER_DEADLINE, '0);
        add_op(KIND_START, 2, NEVER_DEADLINE, '0);
        add_op(KIND_ARM, 2, 64'd100, '0);
        add_op(KIND_SERVICE, 2, 64'd100, '0);
        add_op(KIND_SERVICE, 2, 64'd5000, '0);
        add_op(KIND_ARM, 3, '0, 32'hFFFF_FFFF);
        add_op(KIND_SERVICE, 3, 64'hFFFF_FFFF_FFFF_FFFE, '0);
        add_op(KIND_ARM, 3, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
        add_op(KIND_DISARM, 3, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA);
        add_op(KIND_RSVD_FIRST, 2, '0, '0);
        add_op(KIND_RSVD_LAST, 3, NEVER_DEADLINE, 32'hFFFF_FFFF);
        add_op(KIND_CLEAR, 2, '0, '0);
        add_op(KIND_START, 0, '0, '0);
        add_op(KIND_ARM, 0, '0, 32'd500);
        add_op(KIND_SERVICE, 0, 64'd1000, '0);
        run_random(300);

        // smallest period, no idling on either side
        set_period(32'd1);
        no_idle = 1'b1;
        run_random(250);

        // zero period: tick sits at now and never advances
        set_period('0);
        no_idle = 1'b0;
        add_op(KIND_START, 1, 64'd777, '0);
        add_op(KIND_SERVICE, 1, 64'd777, '0);
        add_op(KIND_SERVICE, 1, 64'd777, '0);
        run_random(200);

        // largest period, with the receiver backing the block up
        set_period(32'hFFFF_FFFF);
        hold_requests++;
        add_op(KIND_START, 0, NEVER_DEADLINE - 5, '0);
        add_op(KIND_SERVICE, 0, NEVER_DEADLINE, '0);
        add_op(KIND_ARM, 0, NEVER_DEADLINE, 32'hFFFF_FFFF);
        run_random(300);

        // time base just short of the 64-bit wrap
        set_period(PERIOD_W'($urandom_range(2, 5000)));
        time_base = NEVER_DEADLINE - 64'd50000;
        run_random(350);

        set_period($urandom);
        run_random(300);

        set_period(32'd37);
        run_random(300);

        drain();
        if (mismatches == 0)
            $display("tb_dual_deadline_timer_compare OK");
        else
            $display("tb_dual_deadline_timer_compare NOT OK");
        $finish;
    end

endmodule
